// ===== src/periodic_timer_table_assert.svh =====
// Assertion macros used by the timer table datapath.
// Each takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// consequence holds in the same cycle as the condition
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// consequence holds in the cycle after the condition
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`else

`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ptt_pkg.sv =====
package ptt_pkg;

	// slot count; ids are five bits wide, so no more than thirty-two slots are used
	localparam int TIMER_SLOTS  = 32;
	localparam int ACTIVE_SLOTS = (TIMER_SLOTS > 32) ? 32 : TIMER_SLOTS;
	localparam int SLOT_W       = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
	localparam int CNT_W        = $clog2(ACTIVE_SLOTS + 1);
	localparam int PERIOD_W     = 24;
	localparam int ID_W         = 5;
	localparam int KIND_W       = 3;
	localparam int CMD_W        = 2;

	localparam logic [CNT_W-1:0] CNT_END    = CNT_W'(ACTIVE_SLOTS);
	localparam logic [ID_W:0]    ACTIVE_LIM = (ID_W + 1)'(ACTIVE_SLOTS);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADDED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_REMOVED   = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_FIRED     = 3'd4,
		KIND_TICK_DONE = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_ADD,
		ST_REMOVE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  cmd_load;
		logic  cnt_clr;
		logic  cnt_inc;
		logic  tick_wr;
		logic  add_wr;
		logic  rm_clr;
		logic  emit;
		kind_t emit_kind;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_end;
		logic slot_valid;
		logic slot_fire;
		logic rm_hit;
		logic out_free;
	} sts_t;

endpackage

// ===== src/ptt_ctrl.sv =====
module ptt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    cmd,
	input  ptt_pkg::sts_t sts,
	output ptt_pkg::ctl_t ctl
);

	ptt_pkg::state_t state_q;
	ptt_pkg::state_t state_nxt;
	logic            accept;

	assign accept = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (ptt_pkg::cmd_t'(cmd))
						ptt_pkg::CMD_TICK:   state_nxt = ptt_pkg::ST_TICK;
						ptt_pkg::CMD_ADD:    state_nxt = ptt_pkg::ST_ADD;
						ptt_pkg::CMD_REMOVE: state_nxt = ptt_pkg::ST_REMOVE;
						default:             state_nxt = ptt_pkg::ST_IDLE;
					endcase
				end
			end
			ptt_pkg::ST_TICK: begin
				if (sts.cnt_end && sts.out_free) begin
					state_nxt = ptt_pkg::ST_IDLE;
				end
			end
			ptt_pkg::ST_ADD: begin
				if (sts.out_free && (sts.cnt_end || !sts.slot_valid)) begin
					state_nxt = ptt_pkg::ST_IDLE;
				end
			end
			ptt_pkg::ST_REMOVE: begin
				if (sts.out_free) begin
					state_nxt = ptt_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ptt_pkg::ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		in_ready      = 1'b0;
		ctl           = '0;
		ctl.emit_kind = ptt_pkg::KIND_TICK_DONE;
		unique case (state_q)
			ptt_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				ctl.cmd_load = accept;
				ctl.cnt_clr  = accept;
			end
			ptt_pkg::ST_TICK: begin
				if (sts.cnt_end) begin
					ctl.emit      = sts.out_free;
					ctl.emit_kind = ptt_pkg::KIND_TICK_DONE;
				end else if (!sts.slot_valid) begin
					ctl.cnt_inc = 1'b1;
				end else if (!sts.slot_fire) begin
					ctl.tick_wr = 1'b1;
					ctl.cnt_inc = 1'b1;
				end else if (sts.out_free) begin
					// restart the slot and report it
					ctl.tick_wr   = 1'b1;
					ctl.cnt_inc   = 1'b1;
					ctl.emit      = 1'b1;
					ctl.emit_kind = ptt_pkg::KIND_FIRED;
				end
			end
			ptt_pkg::ST_ADD: begin
				if (sts.cnt_end) begin
					ctl.emit      = sts.out_free;
					ctl.emit_kind = ptt_pkg::KIND_FULL;
				end else if (sts.slot_valid) begin
					ctl.cnt_inc = 1'b1;
				end else if (sts.out_free) begin
					ctl.add_wr    = 1'b1;
					ctl.emit      = 1'b1;
					ctl.emit_kind = ptt_pkg::KIND_ADDED;
				end
			end
			ptt_pkg::ST_REMOVE: begin
				ctl.emit      = sts.out_free;
				ctl.rm_clr    = sts.out_free && sts.rm_hit;
				ctl.emit_kind = sts.rm_hit ? ptt_pkg::KIND_REMOVED : ptt_pkg::KIND_NOT_FOUND;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/ptt_dp.sv =====
`include "periodic_timer_table_assert.svh"

module ptt_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ptt_pkg::PERIOD_W-1:0]   interval,
	input  logic [ptt_pkg::ID_W-1:0]       timer_id,
	input  ptt_pkg::ctl_t                  ctl,
	output ptt_pkg::sts_t                  sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ptt_pkg::KIND_W-1:0]     kind,
	output logic [ptt_pkg::ID_W-1:0]       timer_id_res,
	output logic                           last
);

	logic [ptt_pkg::CNT_W-1:0]    cnt_q;
	logic [ptt_pkg::SLOT_W-1:0]   idx;
	logic [ptt_pkg::PERIOD_W-1:0] interval_q;
	logic [ptt_pkg::ID_W-1:0]     rm_id_q;
	logic [ptt_pkg::ACTIVE_SLOTS-1:0] valid_q;
	logic [ptt_pkg::PERIOD_W-1:0] period_q  [ptt_pkg::ACTIVE_SLOTS];
	logic [ptt_pkg::PERIOD_W-1:0] elapsed_q [ptt_pkg::ACTIVE_SLOTS];
	logic [ptt_pkg::PERIOD_W-1:0] elapsed_inc;
	logic                         slot_fire;
	logic                         cnt_end;
	logic                         rm_hit;
	logic                         out_free;
	logic                         out_valid_q;
	ptt_pkg::kind_t               kind_q;
	logic [ptt_pkg::ID_W-1:0]     id_res_q;
	logic [ptt_pkg::ID_W-1:0]     emit_id;

	assign idx      = cnt_q[ptt_pkg::SLOT_W-1:0];
	assign cnt_end  = (cnt_q == ptt_pkg::CNT_END);
	assign out_free = !out_valid_q || out_ready;

	// advance the current slot's count and test it against its period
	assign elapsed_inc = elapsed_q[idx] + 1'b1;
	assign slot_fire   = (elapsed_inc >= period_q[idx]);

	// remove hits only a live slot inside the table
	assign rm_hit = ({1'b0, rm_id_q} < ptt_pkg::ACTIVE_LIM)
		&& valid_q[rm_id_q[ptt_pkg::SLOT_W-1:0]];

	assign sts.cnt_end    = cnt_end;
	assign sts.slot_valid = !cnt_end && valid_q[idx];
	assign sts.slot_fire  = slot_fire;
	assign sts.rm_hit     = rm_hit;
	assign sts.out_free   = out_free;

	// capture the request operands
	always_ff @(posedge clk) begin
		if (ctl.cmd_load) begin
			interval_q <= interval;
			rm_id_q    <= timer_id;
		end
	end

	// slot scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctl.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.add_wr) begin
				valid_q[idx] <= 1'b1;
			end
			if (ctl.rm_clr) begin
				valid_q[rm_id_q[ptt_pkg::SLOT_W-1:0]] <= 1'b0;
			end
		end
	end

	// period and count storage
	always_ff @(posedge clk) begin
		if (ctl.add_wr) begin
			period_q[idx]  <= interval_q;
			elapsed_q[idx] <= '0;
		end else if (ctl.tick_wr) begin
			elapsed_q[idx] <= slot_fire ? '0 : elapsed_inc;
		end
	end

	// pick the id reported with each result kind
	always_comb begin
		case (ctl.emit_kind) inside
			ptt_pkg::KIND_ADDED, ptt_pkg::KIND_FIRED:        emit_id = ptt_pkg::ID_W'(idx);
			ptt_pkg::KIND_REMOVED, ptt_pkg::KIND_NOT_FOUND:  emit_id = rm_id_q;
			default:                                         emit_id = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			kind_q   <= ctl.emit_kind;
			id_res_q <= emit_id;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign timer_id_res = id_res_q;
	assign last         = (kind_q != ptt_pkg::KIND_FIRED);

	// checks
	`PTT_ASSERT_NOW(a_emit_room, clk, arst_n, ctl.emit, out_free)
	`PTT_ASSERT_NOW(a_add_free_slot, clk, arst_n, ctl.add_wr, !cnt_end && !valid_q[idx])
	`PTT_ASSERT_NOW(a_rm_live_slot, clk, arst_n, ctl.rm_clr, rm_hit)
	`PTT_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= ptt_pkg::CNT_END)
	`PTT_ASSERT_NEXT(a_add_sets_valid, clk, arst_n, ctl.add_wr, valid_q[$past(idx)])

endmodule

// ===== src/periodic_timer_table.sv =====
// Add and remove requests each report one result through the output register.
// A tick scans one slot a cycle; each fired event waits for the output register to drain.
// One request at a time; the next is taken once the previous one finishes.
// Reset: arst_n clears all slot valid bits, the controller and the output register.
module periodic_timer_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ptt_pkg::CMD_W-1:0]    cmd,
	input  logic [ptt_pkg::PERIOD_W-1:0] interval,
	input  logic [ptt_pkg::ID_W-1:0]     timer_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ptt_pkg::KIND_W-1:0]   kind,
	output logic [ptt_pkg::ID_W-1:0]     timer_id_res,
	output logic                         last
);

	ptt_pkg::ctl_t ctl;
	ptt_pkg::sts_t sts;

	// sequence each request
	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts),
		.ctl      (ctl)
	);

	// slot storage and result register
	ptt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.interval     (interval),
		.timer_id     (timer_id),
		.ctl          (ctl),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.timer_id_res (timer_id_res),
		.last         (last)
	);

endmodule
